### src/wrtc_pkg.sv
// ----------------------------------------------------------------------------
// wrtc_pkg
// shared types and codes for the wildcard rule table classifier
// ----------------------------------------------------------------------------
package wrtc_pkg;

    // request commands
    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_DELETE   = 2'd1;
    localparam logic [1:0] CMD_CLASSIFY = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_POS = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    // one stored filter rule
    typedef struct packed {
        logic [15:0] local_port;
        logic [31:0] remote_addr;
        logic [15:0] remote_port;
        logic [7:0]  protocol;
        logic        target;
    } t_rule;

    // packet header fields that travel down the chain
    typedef struct packed {
        logic [15:0] local_port;
        logic [31:0] remote_addr;
        logic [15:0] remote_port;
        logic [7:0]  protocol;
    } t_key;

    // running lookup state that travels with the key
    typedef struct packed {
        logic valid;
        logic found;
        logic verdict;
    } t_scan;

    // per-cell control from the table controller
    typedef struct packed {
        logic load_left;
        logic load_right;
        logic active;
    } t_cell_ctl;

endpackage

### src/wrtc_cell.sv
// ----------------------------------------------------------------------------
// wrtc_cell
// one rule slot of the chain with its lookup stage
// ----------------------------------------------------------------------------
module wrtc_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wrtc_pkg::t_cell_ctl i_ctl,
    input  wrtc_pkg::t_rule    i_left_rule,
    input  wrtc_pkg::t_rule    i_right_rule,
    output wrtc_pkg::t_rule    o_rule,
    input  wrtc_pkg::t_key     i_key,
    input  wrtc_pkg::t_scan    i_scan,
    output wrtc_pkg::t_key     o_key,
    output wrtc_pkg::t_scan    o_scan
);

    wrtc_pkg::t_rule r_rule;
    wrtc_pkg::t_key  r_key;
    wrtc_pkg::t_scan r_scan;
    wrtc_pkg::t_scan n_scan;
    logic            hit;

    // zero in a port or address field of the rule is a wildcard
    always_comb begin
        hit = i_scan.valid && i_ctl.active && !i_scan.found
            && (r_rule.local_port == 16'd0 || r_rule.local_port == i_key.local_port)
            && (r_rule.remote_addr == 32'd0 || r_rule.remote_addr == i_key.remote_addr)
            && (r_rule.remote_port == 16'd0 || r_rule.remote_port == i_key.remote_port)
            && (r_rule.protocol == i_key.protocol);
        n_scan.valid   = i_scan.valid;
        n_scan.found   = i_scan.found || hit;
        n_scan.verdict = i_scan.found ? i_scan.verdict : (hit && r_rule.target);
    end

    // insert shifts toward the tail, delete pulls from the tail side
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_left) begin
            r_rule <= i_left_rule;
        end else if (i_ctl.load_right) begin
            r_rule <= i_right_rule;
        end
        r_key <= i_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
        end
    end

    assign o_rule = r_rule;
    assign o_key  = r_key;
    assign o_scan = r_scan;

endmodule

### src/wildcard_rule_table_classifier.sv
// ----------------------------------------------------------------------------
// wildcard_rule_table_classifier
// ordered first-match packet filter rule table built as a chain of rule cells
// ----------------------------------------------------------------------------
// usage
// - input channel (i_in_valid / o_in_stall) carries one request: insert a rule
//   at the front, delete the rule at a 1-based position, or classify a header
// - output channel (o_out_valid / i_out_stall) returns one result per request:
//   verdict, matched flag, status and the rule count after the request
// - insert, delete and the unused command finish in the accept cycle and
//   their result is registered, so one such request per cycle while the output is not stalled
// - classify sends the header down the chain, one cell per cycle, and the
//   result is registered once it leaves the last cell; one classify runs at
//   a time
// - a finished result waits in the output register; while it is stalled a
//   next request is still accepted and its result parks in a hold register
// - synchronous active-low reset empties the table (count zero) and clears
//   all valids; rule contents are not cleared
// ----------------------------------------------------------------------------
module wildcard_rule_table_classifier #(
    parameter int MAX_RULES = 16,
    parameter int CNT_W     = $clog2(MAX_RULES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_cmd,
    input  logic [15:0]       i_local_port,
    input  logic [31:0]       i_remote_addr,
    input  logic [15:0]       i_remote_port,
    input  logic [7:0]        i_protocol,
    input  logic              i_rule_target,
    input  logic [CNT_W-1:0]  i_position,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_verdict,
    output logic              o_matched,
    output logic [1:0]        o_status,
    output logic [CNT_W-1:0]  o_count
);

    // controller states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;

    // output register
    logic             r_out_valid, n_out_valid;
    logic             r_out_verdict, r_out_matched;
    logic [1:0]       r_out_status;
    logic [CNT_W-1:0] r_out_count;

    // hold register for a result that finds the output busy
    logic             r_pend_verdict, r_pend_matched;
    logic [1:0]       r_pend_status;
    logic [CNT_W-1:0] r_pend_count;

    // result produced this cycle
    logic             res_ready;
    logic             res_verdict, res_matched;
    logic [1:0]       res_status;
    logic [CNT_W-1:0] res_count;

    logic in_acc, out_free, do_ins, do_del;

    // chain wiring
    wrtc_pkg::t_rule     chain_rule [MAX_RULES];
    wrtc_pkg::t_key      chain_key  [MAX_RULES+1];
    wrtc_pkg::t_scan     chain_scan [MAX_RULES+1];
    wrtc_pkg::t_cell_ctl cell_ctl   [MAX_RULES];
    wrtc_pkg::t_rule     new_rule;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // new rule and lookup key come straight from the request
    assign new_rule = '{local_port: i_local_port, remote_addr: i_remote_addr,
                        remote_port: i_remote_port, protocol: i_protocol,
                        target: i_rule_target};
    assign chain_key[0]  = '{local_port: i_local_port, remote_addr: i_remote_addr,
                             remote_port: i_remote_port, protocol: i_protocol};
    assign chain_scan[0] = '{valid: in_acc && (i_cmd == wrtc_pkg::CMD_CLASSIFY),
                             found: 1'b0, verdict: 1'b0};

    // controller
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        res_ready   = 1'b0;
        res_verdict = 1'b0;
        res_matched = 1'b0;
        res_status  = wrtc_pkg::STATUS_OK;
        res_count   = r_count;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_cmd)
                        wrtc_pkg::CMD_INSERT: begin
                            if (r_count == CNT_W'(MAX_RULES)) begin
                                res_status = wrtc_pkg::STATUS_FULL;
                            end else begin
                                do_ins  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                            res_ready = 1'b1;
                        end
                        wrtc_pkg::CMD_DELETE: begin
                            if (i_position == '0 || i_position > r_count) begin
                                res_status = wrtc_pkg::STATUS_BAD_POS;
                            end else begin
                                do_del  = 1'b1;
                                n_count = r_count - CNT_W'(1);
                            end
                            res_ready = 1'b1;
                        end
                        wrtc_pkg::CMD_CLASSIFY: begin
                            n_state = ST_SCAN;
                        end
                        default: begin
                            // unused command: no change, report current count
                            res_ready = 1'b1;
                        end
                    endcase
                    res_count = n_count;
                end
            end
            ST_SCAN: begin
                // header leaves the last cell
                if (chain_scan[MAX_RULES].valid) begin
                    res_ready   = 1'b1;
                    res_verdict = chain_scan[MAX_RULES].verdict;
                    res_matched = chain_scan[MAX_RULES].found;
                    n_state     = ST_IDLE;
                end
            end
            ST_HOLD: begin
                res_ready   = 1'b1;
                res_verdict = r_pend_verdict;
                res_matched = r_pend_matched;
                res_status  = r_pend_status;
                res_count   = r_pend_count;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // output busy: park the result
        if (res_ready && !out_free) begin
            n_state = ST_HOLD;
        end

        n_out_valid = r_out_valid && i_out_stall;
        if (res_ready && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && out_free) begin
            r_out_verdict <= res_verdict;
            r_out_matched <= res_matched;
            r_out_status  <= res_status;
            r_out_count   <= res_count;
        end
        if (res_ready && !out_free) begin
            r_pend_verdict <= res_verdict;
            r_pend_matched <= res_matched;
            r_pend_status  <= res_status;
            r_pend_count   <= res_count;
        end
    end

    // rule cells, slot 0 holds the newest rule
    for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
        wrtc_pkg::t_rule left_rule, right_rule;

        // cells at and behind the deleted slot pull from their tail neighbor
        assign cell_ctl[i] = '{load_left:  do_ins,
                               load_right: do_del && (CNT_W'(i + 1) >= i_position),
                               active:     (CNT_W'(i) < r_count)};

        if (i == 0) begin : g_head
            assign left_rule = new_rule;
        end else begin : g_body
            assign left_rule = chain_rule[i-1];
        end

        if (i == MAX_RULES - 1) begin : g_tail
            assign right_rule = chain_rule[i];
        end else begin : g_mid
            assign right_rule = chain_rule[i+1];
        end

        wrtc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl[i]),
            .i_left_rule  (left_rule),
            .i_right_rule (right_rule),
            .o_rule       (chain_rule[i]),
            .i_key        (chain_key[i]),
            .i_scan       (chain_scan[i]),
            .o_key        (chain_key[i+1]),
            .o_scan       (chain_scan[i+1])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_out_verdict;
    assign o_matched   = r_out_matched;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;

endmodule

### src/wrtc_checker.sv
// ----------------------------------------------------------------------------
// wrtc_checker
// port-level checks for the wildcard rule table classifier
// ----------------------------------------------------------------------------
module wrtc_checker #(
    parameter int MAX_RULES = 16,
    parameter int CNT_W     = $clog2(MAX_RULES + 1)
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic             o_verdict,
    input logic             o_matched,
    input logic [1:0]       o_status,
    input logic [CNT_W-1:0] o_count
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_count)
            && $stable(o_status) && $stable(o_verdict) && $stable(o_matched))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_count <= CNT_W'(MAX_RULES))
        else $error("rule count beyond table size");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == wrtc_pkg::STATUS_FULL |-> o_count == CNT_W'(MAX_RULES))
        else $error("table full reported with room left");

    a_verdict_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_matched |-> !o_verdict)
        else $error("drop verdict without a matching rule");

endmodule

bind wildcard_rule_table_classifier wrtc_checker #(.MAX_RULES(MAX_RULES), .CNT_W(CNT_W)) u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_verdict   (o_verdict),
    .o_matched   (o_matched),
    .o_status    (o_status),
    .o_count     (o_count)
);
